FILE: rtl/core/kpm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpm_pkg
// Shared types, codes and widths of the key position to MIDI mapper.
// ----------------------------------------------------------------------------
package kpm_pkg;

  localparam int PositionBits = 16;
  localparam int MagBits      = (PositionBits > 16) ? PositionBits : 16;
  localparam int DiffBits     = MagBits + 1;
  localparam int GainBits     = 16;
  localparam int ProdBits     = MagBits + GainBits;
  localparam int VelShift     = 16;
  localparam int AtShift      = PositionBits - 2 + 8;
  localparam int CmdDepth     = 2;
  localparam int PaddrBits    = 5;
  localparam int PdataBits    = 32;

  localparam logic [6:0] VelMissingValue  = 7'd63;
  localparam logic [6:0] PercMissingValue = 7'd0;
  localparam logic [6:0] DataMax          = 7'd127;

  typedef enum logic [2:0] {
    KIND_PRESS   = 3'd0,
    KIND_RELEASE = 3'd1,
    KIND_PERC    = 3'd2,
    KIND_TICK    = 3'd3,
    KIND_RESET   = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    MSG_NOTE_ON  = 2'd0,
    MSG_NOTE_OFF = 2'd1,
    MSG_POLY_AT  = 2'd2
  } msg_e;

  typedef enum logic [2:0] {
    OP_NOTE_ON,
    OP_NOTE_OFF,
    OP_NOTE_OFF_DUAL,
    OP_PERC_ON,
    OP_AFTERTOUCH
  } op_e;

  typedef enum logic [2:0] {
    REG_NOTE_NUMBER  = 3'd0,
    REG_MAIN_CHANNEL = 3'd1,
    REG_PERC_CHANNEL = 3'd2,
    REG_AT_THRESHOLD = 3'd3,
    REG_AT_GAIN      = 3'd4,
    REG_PRESS_GAIN   = 3'd5,
    REG_RELEASE_GAIN = 3'd6,
    REG_PERC_GAIN    = 3'd7
  } reg_e;

  typedef struct packed {
    logic [2:0]                     kind;
    logic signed [15:0]             velocity;
    logic                           velocity_missing;
    logic signed [15:0]             percussiveness;
    logic                           perc_missing;
    logic signed [PositionBits-1:0] position;
    logic                           position_present;
  } in_word_t;

  typedef struct packed {
    logic [1:0] msg_type;
    logic [3:0] channel;
    logic [6:0] note;
    logic [6:0] data_value;
    logic       last;
  } out_word_t;

  typedef struct packed {
    logic [6:0]          note_number;
    logic [3:0]          main_channel;
    logic [4:0]          perc_channel;
    logic signed [15:0]  aftertouch_threshold;
    logic [GainBits-1:0] aftertouch_gain;
    logic [GainBits-1:0] press_gain;
    logic [GainBits-1:0] release_gain;
    logic [GainBits-1:0] perc_gain;
  } cfg_t;

  typedef struct packed {
    op_e                op;
    logic               missing;
    logic [MagBits-1:0] mag;
  } cmd_t;

endpackage

FILE: rtl/core/kpm_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpm_front
// Accepts key events, tracks the note flag and turns each event into a
// command for the back end, or drops it.
// ----------------------------------------------------------------------------
module kpm_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  kpm_pkg::in_word_t in_word_i,
  input  kpm_pkg::cfg_t   cfg_i,
  output logic            cmd_valid_o,
  input  logic            cmd_ready_i,
  output kpm_pkg::cmd_t   cmd_o
);

  logic                                note_active_q, note_active_d;
  logic                                push;
  logic                                perc_on;
  logic signed [kpm_pkg::DiffBits-1:0] pos_ext, thr_ext, diff;
  logic [kpm_pkg::MagBits-1:0]         vel_mag, perc_mag;

  assign perc_on  = ~cfg_i.perc_channel[4];
  assign pos_ext  = kpm_pkg::DiffBits'(in_word_i.position);
  assign thr_ext  = kpm_pkg::DiffBits'(cfg_i.aftertouch_threshold);
  assign diff     = pos_ext - thr_ext;
  // non-positive values scale to zero
  assign vel_mag  = in_word_i.velocity[15] ? '0
                                           : kpm_pkg::MagBits'(in_word_i.velocity[14:0]);
  assign perc_mag = in_word_i.percussiveness[15] ? '0
                                           : kpm_pkg::MagBits'(in_word_i.percussiveness[14:0]);

  always_comb begin
    push          = 1'b0;
    note_active_d = note_active_q;
    cmd_o.op      = kpm_pkg::OP_NOTE_ON;
    cmd_o.missing = 1'b0;
    cmd_o.mag     = '0;
    case (in_word_i.kind)
      kpm_pkg::KIND_PRESS: begin
        if (!note_active_q) begin
          push          = 1'b1;
          cmd_o.op      = kpm_pkg::OP_NOTE_ON;
          cmd_o.missing = in_word_i.velocity_missing;
          cmd_o.mag     = vel_mag;
          note_active_d = 1'b1;
        end
      end
      kpm_pkg::KIND_RELEASE: begin
        if (note_active_q) begin
          push          = 1'b1;
          cmd_o.op      = perc_on ? kpm_pkg::OP_NOTE_OFF_DUAL : kpm_pkg::OP_NOTE_OFF;
          cmd_o.missing = in_word_i.velocity_missing;
          cmd_o.mag     = vel_mag;
          note_active_d = 1'b0;
        end
      end
      kpm_pkg::KIND_PERC: begin
        if (perc_on) begin
          push          = 1'b1;
          cmd_o.op      = kpm_pkg::OP_PERC_ON;
          cmd_o.missing = in_word_i.perc_missing;
          cmd_o.mag     = perc_mag;
        end
      end
      kpm_pkg::KIND_TICK: begin
        if (in_word_i.position_present && note_active_q) begin
          push          = 1'b1;
          cmd_o.op      = kpm_pkg::OP_AFTERTOUCH;
          // below threshold gives zero pressure
          cmd_o.mag     = diff[kpm_pkg::DiffBits-1] ? '0 : diff[kpm_pkg::MagBits-1:0];
        end
      end
      kpm_pkg::KIND_RESET: begin
        note_active_d = 1'b0;
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end

  assign in_ready_o  = cmd_ready_i;
  assign cmd_valid_o = in_valid_i & push;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      note_active_q <= 1'b0;
    end else if (in_valid_i && cmd_ready_i) begin
      note_active_q <= note_active_d;
    end
  end

endmodule

FILE: rtl/core/kpm_cmd_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpm_cmd_fifo
// Short command queue between the front end and the back end.
// ----------------------------------------------------------------------------
module kpm_cmd_fifo #(
  parameter int Depth = kpm_pkg::CmdDepth
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  kpm_pkg::cmd_t push_data_i,
  output logic          pop_valid_o,
  input  logic          pop_ready_i,
  output kpm_pkg::cmd_t pop_data_o
);

  localparam int PtrBits = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntBits = $clog2(Depth + 1);

  kpm_pkg::cmd_t      mem_q [Depth];
  logic [PtrBits-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntBits-1:0] count_q;
  logic               do_push, do_pop;

  assign push_ready_o = (count_q != CntBits'(Depth));
  assign pop_valid_o  = (count_q != '0);
  assign do_push      = push_valid_i & push_ready_o;
  assign do_pop       = pop_valid_o & pop_ready_i;
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrBits'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrBits'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

FILE: rtl/core/kpm_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpm_back
// Scales the command operand, saturates it and builds the MIDI words,
// sending a second note-off word on the percussion channel when asked.
// ----------------------------------------------------------------------------
module kpm_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  kpm_pkg::cfg_t      cfg_i,
  input  logic               cmd_valid_i,
  output logic               cmd_ready_o,
  input  kpm_pkg::cmd_t      cmd_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output kpm_pkg::out_word_t out_word_o
);

  logic [kpm_pkg::GainBits-1:0] gain;
  logic [kpm_pkg::ProdBits-1:0] prod, shifted;

  logic                         m_valid_q;
  kpm_pkg::op_e                 m_op_q;
  logic                         m_missing_q;
  logic [kpm_pkg::ProdBits-1:0] m_prod_q;

  logic [6:0]                   sat, data;
  logic [6:0]                   last_pressure_q;
  logic                         emit, m_adv, out_free, out_fire;
  kpm_pkg::out_word_t           msg;

  logic                         out_valid_q, sec_q;
  kpm_pkg::out_word_t           out_q;

  // multiply stage
  always_comb begin
    case (cmd_i.op)
      kpm_pkg::OP_NOTE_ON:       gain = cfg_i.press_gain;
      kpm_pkg::OP_NOTE_OFF:      gain = cfg_i.release_gain;
      kpm_pkg::OP_NOTE_OFF_DUAL: gain = cfg_i.release_gain;
      kpm_pkg::OP_PERC_ON:       gain = cfg_i.perc_gain;
      kpm_pkg::OP_AFTERTOUCH:    gain = cfg_i.aftertouch_gain;
      default:                   gain = '0;
    endcase
  end

  assign prod = kpm_pkg::ProdBits'(cmd_i.mag) * kpm_pkg::ProdBits'(gain);

  // saturate and build the word
  assign shifted = (m_op_q == kpm_pkg::OP_AFTERTOUCH) ? (m_prod_q >> kpm_pkg::AtShift)
                                                      : (m_prod_q >> kpm_pkg::VelShift);
  assign sat = (shifted > kpm_pkg::ProdBits'(kpm_pkg::DataMax)) ? kpm_pkg::DataMax
                                                                : shifted[6:0];

  always_comb begin
    data           = sat;
    msg.msg_type   = kpm_pkg::MSG_NOTE_ON;
    msg.channel    = cfg_i.main_channel;
    msg.note       = cfg_i.note_number;
    msg.last       = 1'b1;
    emit           = 1'b1;
    case (m_op_q)
      kpm_pkg::OP_NOTE_ON: begin
        if (m_missing_q) begin
          data = kpm_pkg::VelMissingValue;
        end
      end
      kpm_pkg::OP_NOTE_OFF: begin
        msg.msg_type = kpm_pkg::MSG_NOTE_OFF;
        if (m_missing_q) begin
          data = kpm_pkg::VelMissingValue;
        end
      end
      kpm_pkg::OP_NOTE_OFF_DUAL: begin
        msg.msg_type = kpm_pkg::MSG_NOTE_OFF;
        msg.last     = 1'b0;
        if (m_missing_q) begin
          data = kpm_pkg::VelMissingValue;
        end
      end
      kpm_pkg::OP_PERC_ON: begin
        msg.channel = cfg_i.perc_channel[3:0];
        if (m_missing_q) begin
          data = kpm_pkg::PercMissingValue;
        end
      end
      kpm_pkg::OP_AFTERTOUCH: begin
        msg.msg_type = kpm_pkg::MSG_POLY_AT;
        emit         = (sat != last_pressure_q);
      end
      default: begin
        emit = 1'b0;
      end
    endcase
    msg.data_value = data;
  end

  assign out_fire    = out_valid_q & out_ready_i;
  assign out_free    = !out_valid_q || (out_ready_i && !sec_q);
  assign m_adv       = m_valid_q & out_free;
  assign cmd_ready_o = !m_valid_q || m_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q       <= 1'b0;
      out_valid_q     <= 1'b0;
      sec_q           <= 1'b0;
      last_pressure_q <= '0;
    end else begin
      if (cmd_ready_o) begin
        m_valid_q <= cmd_valid_i;
      end
      if (m_adv && emit) begin
        out_valid_q <= 1'b1;
        sec_q       <= (m_op_q == kpm_pkg::OP_NOTE_OFF_DUAL);
      end else if (out_fire) begin
        if (sec_q) begin
          sec_q <= 1'b0;
        end else begin
          out_valid_q <= 1'b0;
        end
      end
      if (m_adv) begin
        if (m_op_q == kpm_pkg::OP_NOTE_OFF || m_op_q == kpm_pkg::OP_NOTE_OFF_DUAL) begin
          last_pressure_q <= '0;
        end else if (m_op_q == kpm_pkg::OP_AFTERTOUCH) begin
          last_pressure_q <= sat;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_ready_o && cmd_valid_i) begin
      m_op_q      <= cmd_i.op;
      m_missing_q <= cmd_i.missing;
      m_prod_q    <= prod;
    end
    if (m_adv && emit) begin
      out_q <= msg;
    end else if (out_fire && sec_q) begin
      // percussion copy of the note-off
      out_q.channel <= cfg_i.perc_channel[3:0];
      out_q.last    <= 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

FILE: rtl/core/key_position_to_midi_mapper_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_position_to_midi_mapper_top
// Maps key events of one key to MIDI note-on, note-off and aftertouch words.
//
// Input channel (in_valid_i / in_ready_o / in_word_i) takes key event words:
// press, release, percussiveness, position tick and reset. Output channel
// (out_valid_o / out_ready_i / out_word_o) gives MIDI words; last marks the
// final word caused by an input word. Registers are set over the APB port
// by the user, only while the block is idle; the block does not enforce it.
// An input word that produces output passes the command queue, the multiply
// register and the output register, in that order.
// Throughput: one input word per cycle while the command queue has room; a
// release with the percussion channel enabled holds the output register for
// two words, set by the single output register and its second note-off.
// Reset clears the note flag, the last aftertouch value, the queue and the
// output; registers return to note 60, channel 0, percussion off, gains 0.
// When the receiver stalls, the output word holds, the multiply register and
// the command queue fill and then in_ready_o drops.
// ----------------------------------------------------------------------------
module key_position_to_midi_mapper_top #(
  parameter int CmdDepth = kpm_pkg::CmdDepth
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  kpm_pkg::in_word_t                 in_word_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output kpm_pkg::out_word_t                out_word_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [kpm_pkg::PaddrBits-1:0]     paddr,
  input  logic [kpm_pkg::PdataBits-1:0]     pwdata,
  output logic [kpm_pkg::PdataBits-1:0]     prdata,
  output logic                              pready
);

  kpm_pkg::cfg_t cfg_q;
  kpm_pkg::reg_e reg_idx;
  logic          cfg_we;

  logic          cmd_in_valid, cmd_in_ready, cmd_out_valid, cmd_out_ready;
  kpm_pkg::cmd_t cmd_in, cmd_out;

  assign pready  = 1'b1;
  assign reg_idx = kpm_pkg::reg_e'(paddr[4:2]);
  assign cfg_we  = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.note_number          <= 7'd60;
      cfg_q.main_channel         <= '0;
      cfg_q.perc_channel         <= 5'd16;
      cfg_q.aftertouch_threshold <= '0;
      cfg_q.aftertouch_gain      <= '0;
      cfg_q.press_gain           <= '0;
      cfg_q.release_gain         <= '0;
      cfg_q.perc_gain            <= '0;
    end else if (cfg_we) begin
      case (reg_idx)
        kpm_pkg::REG_NOTE_NUMBER:  cfg_q.note_number          <= pwdata[6:0];
        kpm_pkg::REG_MAIN_CHANNEL: cfg_q.main_channel         <= pwdata[3:0];
        kpm_pkg::REG_PERC_CHANNEL: cfg_q.perc_channel         <= pwdata[4:0];
        kpm_pkg::REG_AT_THRESHOLD: cfg_q.aftertouch_threshold <= pwdata[15:0];
        kpm_pkg::REG_AT_GAIN:      cfg_q.aftertouch_gain      <= pwdata[15:0];
        kpm_pkg::REG_PRESS_GAIN:   cfg_q.press_gain           <= pwdata[15:0];
        kpm_pkg::REG_RELEASE_GAIN: cfg_q.release_gain         <= pwdata[15:0];
        kpm_pkg::REG_PERC_GAIN:    cfg_q.perc_gain            <= pwdata[15:0];
        default: begin
          cfg_q.note_number <= cfg_q.note_number;
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      kpm_pkg::REG_NOTE_NUMBER:  prdata = kpm_pkg::PdataBits'(cfg_q.note_number);
      kpm_pkg::REG_MAIN_CHANNEL: prdata = kpm_pkg::PdataBits'(cfg_q.main_channel);
      kpm_pkg::REG_PERC_CHANNEL: prdata = kpm_pkg::PdataBits'(cfg_q.perc_channel);
      kpm_pkg::REG_AT_THRESHOLD: prdata = kpm_pkg::PdataBits'(cfg_q.aftertouch_threshold);
      kpm_pkg::REG_AT_GAIN:      prdata = kpm_pkg::PdataBits'(cfg_q.aftertouch_gain);
      kpm_pkg::REG_PRESS_GAIN:   prdata = kpm_pkg::PdataBits'(cfg_q.press_gain);
      kpm_pkg::REG_RELEASE_GAIN: prdata = kpm_pkg::PdataBits'(cfg_q.release_gain);
      kpm_pkg::REG_PERC_GAIN:    prdata = kpm_pkg::PdataBits'(cfg_q.perc_gain);
      default:                   prdata = '0;
    endcase
  end

  kpm_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_word_i   (in_word_i),
    .cfg_i       (cfg_q),
    .cmd_valid_o (cmd_in_valid),
    .cmd_ready_i (cmd_in_ready),
    .cmd_o       (cmd_in)
  );

  kpm_cmd_fifo #(
    .Depth (CmdDepth)
  ) u_cmd_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (cmd_in_valid),
    .push_ready_o (cmd_in_ready),
    .push_data_i  (cmd_in),
    .pop_valid_o  (cmd_out_valid),
    .pop_ready_i  (cmd_out_ready),
    .pop_data_o   (cmd_out)
  );

  kpm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_valid_i (cmd_out_valid),
    .cmd_ready_o (cmd_out_ready),
    .cmd_i       (cmd_out),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

endmodule

FILE: tb/sv/kpm_midi_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpm_midi_checker
// Watches the key event, MIDI and APB ports of the key position to MIDI
// mapper. Keeps its own copy of the registers, the note flag and the last
// aftertouch value, works out the MIDI words each accepted key event must
// produce and compares every accepted MIDI word field by field with the
// oldest one still owed. Hands the mismatch count and the number of owed
// words to the testbench top.
// ----------------------------------------------------------------------------
module kpm_midi_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  kpm_pkg::in_word_t             in_word_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  kpm_pkg::out_word_t            out_word_i,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [kpm_pkg::PaddrBits-1:0] paddr,
  input  logic [kpm_pkg::PdataBits-1:0] pwdata,
  input  logic                          pready,
  output int                            mismatch_count_o,
  output int                            pending_words_o
);

  kpm_pkg::cfg_t      cfg;
  logic               key_down;
  logic [6:0]         held_pressure;
  kpm_pkg::out_word_t owed_midi_q[$];
  kpm_pkg::out_word_t owed;
  int                 mismatch_total = 0;

  function automatic logic [6:0] scale_velocity(logic signed [15:0] v, logic [15:0] gain);
    logic [31:0] prod;
    if (v <= 0) begin
      return 7'd0;
    end
    prod = {16'd0, v} * {16'd0, gain};
    prod = prod >> kpm_pkg::VelShift;
    return (prod > 32'(kpm_pkg::DataMax)) ? kpm_pkg::DataMax : prod[6:0];
  endfunction

  function automatic logic [6:0] pressure_of(logic signed [kpm_pkg::PositionBits-1:0] pos);
    longint p;
    longint t;
    longint q;
    p = longint'($signed(pos));
    t = longint'($signed(cfg.aftertouch_threshold));
    if (p < t) begin
      return 7'd0;
    end
    q = ((p - t) * longint'(cfg.aftertouch_gain)) >>> kpm_pkg::AtShift;
    return (q > longint'(kpm_pkg::DataMax)) ? kpm_pkg::DataMax : q[6:0];
  endfunction

  function automatic kpm_pkg::out_word_t midi_word(kpm_pkg::msg_e t, logic [3:0] ch,
                                                   logic [6:0] d, logic l);
    kpm_pkg::out_word_t m;
    m.msg_type   = t;
    m.channel    = ch;
    m.note       = cfg.note_number;
    m.data_value = d;
    m.last       = l;
    return m;
  endfunction

  function automatic void predict_midi(kpm_pkg::in_word_t w);
    logic [6:0] d;
    logic       perc_on;
    perc_on = cfg.perc_channel < 5'd16;
    case (w.kind)
      kpm_pkg::KIND_PRESS: begin
        if (!key_down) begin
          d = w.velocity_missing ? kpm_pkg::VelMissingValue
                                 : scale_velocity(w.velocity, cfg.press_gain);
          owed_midi_q.push_back(midi_word(kpm_pkg::MSG_NOTE_ON, cfg.main_channel, d, 1'b1));
          key_down = 1'b1;
        end
      end
      kpm_pkg::KIND_RELEASE: begin
        if (key_down) begin
          d = w.velocity_missing ? kpm_pkg::VelMissingValue
                                 : scale_velocity(w.velocity, cfg.release_gain);
          key_down      = 1'b0;
          held_pressure = 7'd0;
          if (perc_on) begin
            owed_midi_q.push_back(midi_word(kpm_pkg::MSG_NOTE_OFF, cfg.main_channel, d, 1'b0));
            owed_midi_q.push_back(midi_word(kpm_pkg::MSG_NOTE_OFF, cfg.perc_channel[3:0],
                                            d, 1'b1));
          end else begin
            owed_midi_q.push_back(midi_word(kpm_pkg::MSG_NOTE_OFF, cfg.main_channel, d, 1'b1));
          end
        end
      end
      kpm_pkg::KIND_PERC: begin
        if (perc_on) begin
          d = w.perc_missing ? kpm_pkg::PercMissingValue
                             : scale_velocity(w.percussiveness, cfg.perc_gain);
          owed_midi_q.push_back(midi_word(kpm_pkg::MSG_NOTE_ON, cfg.perc_channel[3:0],
                                          d, 1'b1));
        end
      end
      kpm_pkg::KIND_TICK: begin
        if (w.position_present && key_down) begin
          d = pressure_of(w.position);
          if (d != held_pressure) begin
            held_pressure = d;
            owed_midi_q.push_back(midi_word(kpm_pkg::MSG_POLY_AT, cfg.main_channel, d, 1'b1));
          end
        end
      end
      kpm_pkg::KIND_RESET: begin
        key_down = 1'b0;
      end
      default: begin
      end
    endcase
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_total++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg              = '0;
      cfg.note_number  = 7'd60;
      cfg.perc_channel = 5'd16;
      key_down         = 1'b0;
      held_pressure    = 7'd0;
      owed_midi_q.delete();
    end else begin
      // output side first: a word leaving now was caused by an earlier event
      if (out_valid_i && out_ready_i) begin
        if (owed_midi_q.size() == 0) begin
          $error("midi word: expected none, got %p", out_word_i);
          mismatch_total++;
        end else begin
          owed = owed_midi_q.pop_front();
          check_field("msg_type", owed.msg_type, out_word_i.msg_type);
          check_field("channel", owed.channel, out_word_i.channel);
          check_field("note", owed.note, out_word_i.note);
          check_field("data_value", owed.data_value, out_word_i.data_value);
          check_field("last", owed.last, out_word_i.last);
        end
      end
      if (in_valid_i && in_ready_i) begin
        predict_midi(in_word_i);
      end
      if (psel && penable && pwrite && pready) begin
        case (kpm_pkg::reg_e'(paddr[kpm_pkg::PaddrBits-1:2]))
          kpm_pkg::REG_NOTE_NUMBER:  cfg.note_number          = pwdata[6:0];
          kpm_pkg::REG_MAIN_CHANNEL: cfg.main_channel         = pwdata[3:0];
          kpm_pkg::REG_PERC_CHANNEL: cfg.perc_channel         = pwdata[4:0];
          kpm_pkg::REG_AT_THRESHOLD: cfg.aftertouch_threshold = pwdata[15:0];
          kpm_pkg::REG_AT_GAIN:      cfg.aftertouch_gain      = pwdata[15:0];
          kpm_pkg::REG_PRESS_GAIN:   cfg.press_gain           = pwdata[15:0];
          kpm_pkg::REG_RELEASE_GAIN: cfg.release_gain         = pwdata[15:0];
          kpm_pkg::REG_PERC_GAIN:    cfg.perc_gain            = pwdata[15:0];
          default: begin
          end
        endcase
      end
    end
    mismatch_count_o <= mismatch_total;
    pending_words_o  <= owed_midi_q.size();
  end

endmodule

FILE: tb/sv/key_position_to_midi_mapper_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_position_to_midi_mapper_top_tb
// Drives key events and register writes into the key position to MIDI
// mapper: a directed run over presses, releases, percussion, aftertouch
// ticks, reset events and ignored kinds at the field extremes, then phases of
// press / tick / release sequences with random content and some noise, each
// phase under new register settings and one of four mixes of sender gaps
// and receiver stalls. A checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module key_position_to_midi_mapper_top_tb;

  localparam int CycleLimit     = 200000;
  localparam int SettleCycles   = 8;
  localparam int PhaseCount     = 8;
  localparam int WordsPerPhase  = 230;
  localparam int InBits         = $bits(kpm_pkg::in_word_t);

  logic                          clk_i;
  logic                          rst_ni;
  logic                          in_valid_i;
  logic                          in_ready_o;
  kpm_pkg::in_word_t             in_word_i;
  logic                          out_valid_o;
  logic                          out_ready_i = 1'b0;
  kpm_pkg::out_word_t            out_word_o;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [kpm_pkg::PaddrBits-1:0] paddr;
  logic [kpm_pkg::PdataBits-1:0] pwdata;
  logic [kpm_pkg::PdataBits-1:0] prdata;
  logic                          pready;

  int            mismatches;
  int            pending_words;
  int            cycle_count    = 0;
  int            send_idle_pct  = 0;
  int            stall_pct      = 0;
  kpm_pkg::cfg_t setting;

  key_position_to_midi_mapper_top i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  kpm_midi_checker i_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_i       (in_ready_o),
    .in_word_i        (in_word_i),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .out_word_i       (out_word_o),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .pready           (pready),
    .mismatch_count_o (mismatches),
    .pending_words_o  (pending_words)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // the value lands in the field the kind uses, the flag in its missing/present bit
  function automatic kpm_pkg::in_word_t key_word(logic [2:0] k, logic [15:0] value,
                                                 logic flag);
    kpm_pkg::in_word_t w;
    w      = InBits'({$urandom, $urandom});
    w.kind = k;
    case (k)
      kpm_pkg::KIND_PRESS, kpm_pkg::KIND_RELEASE: begin
        w.velocity         = value;
        w.velocity_missing = flag;
      end
      kpm_pkg::KIND_PERC: begin
        w.percussiveness = value;
        w.perc_missing   = flag;
      end
      kpm_pkg::KIND_TICK: begin
        w.position         = value;
        w.position_present = flag;
      end
      default: begin
      end
    endcase
    return w;
  endfunction

  function automatic kpm_pkg::in_word_t random_key_word(logic [2:0] k);
    logic [15:0] v;
    logic        flag;
    if (k == kpm_pkg::KIND_TICK) begin
      v    = ($urandom_range(4) == 0) ? 16'($urandom)
           : 16'(setting.aftertouch_threshold + $urandom_range(0, 12000) - 1500);
      flag = ($urandom_range(7) != 0);
    end else begin
      v    = ($urandom_range(3) != 0) ? 16'($urandom_range(0, 400)) - 16'd40
                                      : 16'($urandom);
      flag = ($urandom_range(7) == 0);
    end
    return key_word(k, v, flag);
  endfunction

  task automatic send_word(input kpm_pkg::in_word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      in_word_i  <= InBits'({$urandom, $urandom});
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_words != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_register(kpm_pkg::reg_e r, logic [31:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic program_settings();
    write_register(kpm_pkg::REG_NOTE_NUMBER, 32'(setting.note_number));
    write_register(kpm_pkg::REG_MAIN_CHANNEL, 32'(setting.main_channel));
    write_register(kpm_pkg::REG_PERC_CHANNEL, 32'(setting.perc_channel));
    write_register(kpm_pkg::REG_AT_THRESHOLD, 32'($signed(setting.aftertouch_threshold)));
    write_register(kpm_pkg::REG_AT_GAIN, 32'(setting.aftertouch_gain));
    write_register(kpm_pkg::REG_PRESS_GAIN, 32'(setting.press_gain));
    write_register(kpm_pkg::REG_RELEASE_GAIN, 32'(setting.release_gain));
    write_register(kpm_pkg::REG_PERC_GAIN, 32'(setting.perc_gain));
  endtask

  // mostly press, ticks, release sequences; the rest any kind at all
  task automatic random_traffic(int n);
    int sent;
    int ticks;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(99) < 80) begin
        send_word(random_key_word(kpm_pkg::KIND_PRESS));
        ticks = $urandom_range(1, 6);
        repeat (ticks) begin
          send_word(random_key_word(($urandom_range(9) == 0) ? kpm_pkg::KIND_PERC
                                                             : kpm_pkg::KIND_TICK));
        end
        send_word(random_key_word(($urandom_range(9) == 0) ? kpm_pkg::KIND_RESET
                                                           : kpm_pkg::KIND_RELEASE));
        sent += ticks + 2;
      end else begin
        send_word(random_key_word(3'($urandom_range(7))));
        sent++;
      end
    end
  endtask

  initial begin
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    in_word_i  <= '0;
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    paddr      <= '0;
    pwdata     <= '0;
    setting                  = '0;
    setting.note_number      = 7'd60;
    setting.perc_channel     = 5'd16;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // reset settings: gains zero, percussion off
    send_word(key_word(kpm_pkg::KIND_TICK, 16'h4000, 1'b1));
    send_word(key_word(kpm_pkg::KIND_PRESS, 16'h1234, 1'b0));
    send_word(key_word(kpm_pkg::KIND_PRESS, 16'h7fff, 1'b0));
    send_word(key_word(kpm_pkg::KIND_TICK, 16'h7fff, 1'b1));
    send_word(key_word(kpm_pkg::KIND_PERC, 16'h7fff, 1'b0));
    send_word(key_word(kpm_pkg::KIND_RELEASE, 16'h7fff, 1'b0));
    send_word(key_word(kpm_pkg::KIND_RELEASE, 16'h0040, 1'b0));
    for (int k = kpm_pkg::KIND_RESET + 1; k < 2 ** $bits(kpm_pkg::kind_e); k++) begin
      send_word(key_word(3'(k), 16'($urandom), 1'b0));
    end
    send_word(key_word(kpm_pkg::KIND_RESET, 16'h0000, 1'b0));
    wait_idle();

    setting.note_number          = 7'd127;
    setting.main_channel         = 4'd15;
    setting.perc_channel         = 5'd9;
    setting.aftertouch_threshold = 16'sh4000;
    setting.aftertouch_gain      = 16'hffff;
    setting.press_gain           = 16'hffff;
    setting.release_gain         = 16'h8000;
    setting.perc_gain            = 16'hffff;
    program_settings();

    send_word(key_word(kpm_pkg::KIND_PRESS, 16'h7fff, 1'b0));
    send_word(key_word(kpm_pkg::KIND_TICK, 16'h3fff, 1'b1));
    send_word(key_word(kpm_pkg::KIND_TICK, 16'h7fff, 1'b0));
    send_word(key_word(kpm_pkg::KIND_TICK, 16'h7fff, 1'b1));
    // reset event keeps the last pressure
    send_word(key_word(kpm_pkg::KIND_RESET, 16'h0000, 1'b0));
    send_word(key_word(kpm_pkg::KIND_PRESS, 16'h0000, 1'b1));
    send_word(key_word(kpm_pkg::KIND_TICK, 16'h7fff, 1'b1));
    send_word(key_word(kpm_pkg::KIND_TICK, 16'h4000, 1'b1));
    send_word(key_word(kpm_pkg::KIND_RELEASE, 16'h0000, 1'b1));
    send_word(key_word(kpm_pkg::KIND_PERC, 16'h8000, 1'b0));
    send_word(key_word(kpm_pkg::KIND_PERC, 16'h7fff, 1'b1));
    send_word(key_word(kpm_pkg::KIND_PERC, 16'h7fff, 1'b0));
    send_word(key_word(kpm_pkg::KIND_PRESS, 16'hfffb, 1'b0));
    send_word(key_word(kpm_pkg::KIND_RELEASE, 16'd100, 1'b0));
    send_word(key_word(kpm_pkg::KIND_PRESS, 16'h0000, 1'b0));
    send_word(key_word(kpm_pkg::KIND_TICK, 16'h8000, 1'b1));
    send_word(key_word(kpm_pkg::KIND_RELEASE, 16'h7fff, 1'b0));
    wait_idle();

    for (int p = 0; p < PhaseCount; p++) begin
      setting.note_number  = (p == 0) ? 7'd0 : (p == 1) ? 7'd127 : 7'($urandom);
      setting.main_channel = (p == 0) ? 4'd0 : (p == 1) ? 4'd15 : 4'($urandom);
      case (p)
        0:       setting.perc_channel = 5'd0;
        1:       setting.perc_channel = 5'd15;
        2:       setting.perc_channel = 5'd16;
        5:       setting.perc_channel = 5'd31;
        default: setting.perc_channel = 5'($urandom_range(15));
      endcase
      setting.aftertouch_threshold = (p == 3) ? 16'sh8000 : (p == 4) ? 16'sh7fff
                                                          : 16'($urandom);
      setting.aftertouch_gain = (p == 6) ? 16'h0000 : (p == 7) ? 16'hffff : 16'($urandom);
      setting.press_gain      = (p == 6) ? 16'h0000 : (p == 7) ? 16'hffff : 16'($urandom);
      setting.release_gain    = (p == 6) ? 16'h0000 : (p == 7) ? 16'hffff : 16'($urandom);
      setting.perc_gain       = (p == 6) ? 16'h0000 : (p == 7) ? 16'hffff : 16'($urandom);
      program_settings();
      case (p % 4)
        0: begin
          send_idle_pct = 0;
          stall_pct    <= 0;
        end
        1: begin
          send_idle_pct = 49;
          stall_pct    <= 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct    <= 49;
        end
        default: begin
          send_idle_pct = 34;
          stall_pct    <= 34;
        end
      endcase
      random_traffic(WordsPerPhase / 2);
      // hold off until every owed word is out
      wait_idle();
      random_traffic(WordsPerPhase / 2);
      wait_idle();
    end

    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
